FILE: rtl/lnorm_pkg.sv
package lnorm_pkg;

  // Vector geometry and sample format
  localparam int MAX_LENGTH = 64;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int ELEM_W     = 3 * SAMPLE_W;

  // Configuration register indexes
  localparam logic [1:0] REG_VECTOR_LENGTH    = 2'd0;
  localparam logic [1:0] REG_EPSILON          = 2'd1;
  localparam logic [1:0] REG_NORMALIZE_ENABLE = 2'd2;

  // Iteration counts of the root and divide units
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 18;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              store;     // write input element, update count and sum
    logic              byp;       // load pass-through result, drop partial vector
    logic              rd_en;     // read element store
    logic [ADDR_W-1:0] rd_addr;
    logic              sq_mul;    // square the read value
    logic              sq_acc;    // accumulate the square
    logic              w1;        // n*Q, S^2, n^2
    logic              w2;        // epsilon*n^2
    logic              w3;        // W = nQ - S^2 + eps*n^2
    logic              rt_init;
    logic              rt_step;
    logic              el_num;    // n*x - S
    logic              el_prod;   // times scale
    logic              div_init;
    logic              div_step;
    logic              out_load;  // load normalized result
    logic              out_last;
    logic              clear;     // end of vector
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic             vec_done;   // a store now would complete the vector
    logic             norm_en;
    logic [CNT_W-1:0] n;
  } stat_t;

endpackage

FILE: rtl/layer_normalization.sv
// Layer normalization over token vectors of signed Q8.8 elements, each sent
// with its own scale and shift. Elements of a vector are taken one per cycle
// until the configured length is stored; the block then stops taking input,
// forms the sum of squares (read, square and accumulate for each element,
// through one multiplier), the variance terms (W1, W2, W3), a setup step and
// a 32-step bitwise square root, and emits each result after a divide of 18
// radix-2 steps. The last result of each vector carries tlast. With
// normalize_enable at 0 every element comes back unchanged, one per cycle
// while the output register is free, tlast low, and any partly loaded vector
// is dropped. Configuration writes are always accepted and should be issued
// only while the block is idle.
module layer_normalization (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value[15:0], scale[31:16], shift[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result[15:0]
  output logic        m_axis_tlast
);
  import lnorm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  lnorm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lnorm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

FILE: rtl/lnorm_dp.sv
module lnorm_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic [47:0]            in_data_i,   // value, scale, shift
  input  lnorm_pkg::cmd_t        cmd_i,
  output lnorm_pkg::stat_t       stat_o,
  output logic [15:0]            result_o,
  output logic                   last_o
);
  import lnorm_pkg::*;

  // Configuration
  logic [6:0]  vlen_q;
  logic [15:0] eps_q;
  logic        norm_q;

  // Vector state
  logic [ELEM_W-1:0] mem [MAX_LENGTH];
  logic [ELEM_W-1:0] rd_q;
  logic [CNT_W-1:0]  count_q;
  logic signed [21:0] sum_q;

  // Reduction and root
  logic [31:0] sq_q;
  logic [36:0] qacc_q;
  logic [43:0] nq_q, s2_q, w_q;
  logic [12:0] n2_q;
  logic [28:0] e_q;
  logic [63:0] a_q;
  logic [35:0] rrem_q;
  logic [31:0] root_q;

  // Per element
  logic signed [24:0] num_q;
  logic signed [40:0] prod_q;
  logic signed [15:0] sc_q, sh_q, sh2_q;
  logic        neg_q, ovf_q;
  logic [51:0] drem_q, dsh_q;
  logic [17:0] quo_q;

  logic [15:0] res_q;
  logic        last_q;

  // Effective length and store address
  logic [CNT_W-1:0]  len_eff, cnt_next;
  logic [ADDR_W-1:0] waddr;

  always_comb begin
    if (vlen_q == 7'd0) begin
      len_eff = CNT_W'(1);
    end else if (vlen_q > 7'(MAX_LENGTH)) begin
      len_eff = CNT_W'(MAX_LENGTH);
    end else begin
      len_eff = CNT_W'(vlen_q);
    end
    if (count_q >= CNT_W'(MAX_LENGTH)) begin
      waddr = ADDR_W'(MAX_LENGTH - 1);
    end else begin
      waddr = count_q[ADDR_W-1:0];
    end
    cnt_next = {1'b0, waddr} + CNT_W'(1);
  end

  assign stat_o.vec_done = (cnt_next >= len_eff);
  assign stat_o.norm_en  = norm_q;
  assign stat_o.n        = count_q;

  // Field views
  logic signed [15:0] in_val, rd_val, rd_sc, rd_sh;
  logic [15:0] rd_mag;
  logic [21:0] sabs;
  assign in_val = in_data_i[15:0];
  assign rd_val = rd_q[15:0];
  assign rd_sc  = rd_q[31:16];
  assign rd_sh  = rd_q[47:32];
  assign rd_mag = rd_val[15] ? 16'(-rd_val) : rd_val;
  assign sabs   = sum_q[21] ? 22'(-sum_q) : sum_q;

  // Root step
  logic [35:0] rem_sh, trial;
  assign rem_sh = {rrem_q[33:0], a_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};

  // Divide setup
  logic [40:0] pmag;
  logic [51:0] dnum, dlim;
  assign pmag = prod_q[40] ? 41'(-prod_q) : prod_q;
  assign dnum = {1'b0, pmag[39:0], 11'd0} + {20'd0, root_q};
  assign dlim = {1'b0, root_q, 19'd0};

  // Final rounding result and saturation
  logic signed [20:0] qs, rsum;
  logic signed [15:0] rsat;
  always_comb begin
    qs   = neg_q ? -$signed({3'b000, quo_q}) : $signed({3'b000, quo_q});
    rsum = qs + 21'(sh2_q);
    if (root_q == 32'd0) begin
      rsat = sh2_q;
    end else if (ovf_q) begin
      rsat = neg_q ? 16'sh8000 : 16'sh7fff;
    end else if (rsum > 21'sd32767) begin
      rsat = 16'sh7fff;
    end else if (rsum < -21'sd32768) begin
      rsat = 16'sh8000;
    end else begin
      rsat = rsum[15:0];
    end
  end

  // Control state: configuration, count, sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q  <= 7'(MAX_LENGTH);
      eps_q   <= 16'd1;
      norm_q  <= 1'b1;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_VECTOR_LENGTH:    vlen_q <= cfg_data_i[6:0];
          REG_EPSILON:          eps_q  <= cfg_data_i;
          REG_NORMALIZE_ENABLE: norm_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.byp || cmd_i.clear) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.store) begin
        count_q <= cnt_next;
        sum_q   <= sum_q + 22'(in_val);
      end
    end
  end

  // Element store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[waddr] <= in_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr];
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.store)   qacc_q <= '0;
    if (cmd_i.sq_mul)  sq_q   <= rd_mag * rd_mag;
    if (cmd_i.sq_acc)  qacc_q <= qacc_q + 37'(sq_q);
    if (cmd_i.w1) begin
      nq_q <= 44'(count_q) * 44'(qacc_q);
      s2_q <= 44'(sabs) * 44'(sabs);
      n2_q <= 13'(count_q) * 13'(count_q);
    end
    if (cmd_i.w2) e_q <= 29'(eps_q) * 29'(n2_q);
    if (cmd_i.w3) w_q <= nq_q - s2_q + 44'(e_q);
    if (cmd_i.rt_init) begin
      a_q    <= {w_q, 20'd0};
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_step) begin
      a_q <= {a_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rrem_q <= rem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rrem_q <= rem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.el_num) begin
      num_q <= 25'($signed({1'b0, count_q}) * rd_val) - 25'(sum_q);
      sc_q  <= rd_sc;
      sh_q  <= rd_sh;
    end
    if (cmd_i.el_prod) prod_q <= 41'(num_q * sc_q);
    if (cmd_i.div_init) begin
      neg_q  <= prod_q[40];
      ovf_q  <= (dnum >= dlim);
      drem_q <= dnum;
      dsh_q  <= {2'b00, root_q, 18'd0};
      quo_q  <= '0;
      sh2_q  <= sh_q;
    end else if (cmd_i.div_step) begin
      dsh_q <= {1'b0, dsh_q[51:1]};
      if (drem_q >= dsh_q) begin
        drem_q <= drem_q - dsh_q;
        quo_q  <= {quo_q[16:0], 1'b1};
      end else begin
        quo_q  <= {quo_q[16:0], 1'b0};
      end
    end
    // Output register
    if (cmd_i.byp) begin
      res_q  <= in_val;
      last_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      res_q  <= rsat;
      last_q <= cmd_i.out_last;
    end
  end

  assign result_o = res_q;
  assign last_o   = last_q;

endmodule

FILE: rtl/lnorm_ctrl.sv
module lnorm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  lnorm_pkg::stat_t stat_i,
  output lnorm_pkg::cmd_t  cmd_o
);
  import lnorm_pkg::*;

  typedef enum logic [3:0] {
    S_IN, S_SQ_RD, S_SQ_MUL, S_SQ_ACC, S_W1, S_W2, S_W3, S_RT_INIT, S_RT,
    S_E_RD, S_E_NUM, S_E_PROD, S_E_DIVI, S_E_DIV, S_E_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [4:0]        step_q, step_d;
  logic              ov_q, ov_d;
  logic              out_free, in_xfer, idx_last;

  assign out_free   = !ov_q || out_ready_i;
  // Storing an element leaves the output register alone; only bypass needs it free
  assign in_ready_o = (state_q == S_IN) && (out_free || stat_i.norm_en);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign idx_last   = ({1'b0, idx_q} + CNT_W'(1)) >= stat_i.n;
  assign out_valid_o = ov_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.rd_addr = idx_q;
    case (state_q)
      S_IN: begin
        if (in_xfer) begin
          if (!stat_i.norm_en) begin
            cmd_o.byp = 1'b1;
            ov_d      = 1'b1;
          end else begin
            cmd_o.store = 1'b1;
            if (stat_i.vec_done) begin
              idx_d   = '0;
              state_d = S_SQ_RD;
            end
          end
        end
      end
      S_SQ_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd_o.sq_acc = 1'b1;
        if (idx_last) begin
          state_d = S_W1;
        end else begin
          idx_d   = idx_q + ADDR_W'(1);
          state_d = S_SQ_RD;
        end
      end
      S_W1: begin
        cmd_o.w1 = 1'b1;
        state_d  = S_W2;
      end
      S_W2: begin
        cmd_o.w2 = 1'b1;
        state_d  = S_W3;
      end
      S_W3: begin
        cmd_o.w3 = 1'b1;
        state_d  = S_RT_INIT;
      end
      S_RT_INIT: begin
        cmd_o.rt_init = 1'b1;
        step_d        = '0;
        state_d       = S_RT;
      end
      S_RT: begin
        cmd_o.rt_step = 1'b1;
        step_d        = step_q + 5'd1;
        if (step_q == 5'(ROOT_STEPS - 1)) begin
          idx_d   = '0;
          state_d = S_E_RD;
        end
      end
      S_E_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_E_NUM;
      end
      S_E_NUM: begin
        cmd_o.el_num = 1'b1;
        state_d      = S_E_PROD;
      end
      S_E_PROD: begin
        cmd_o.el_prod = 1'b1;
        state_d       = S_E_DIVI;
      end
      S_E_DIVI: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_E_DIV;
      end
      S_E_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 5'd1;
        if (step_q == 5'(DIV_STEPS - 1)) begin
          state_d = S_E_OUT;
        end
      end
      S_E_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = idx_last;
          ov_d           = 1'b1;
          if (idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IN;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = S_E_RD;
          end
        end
      end
      default: state_d = S_IN;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      idx_q   <= '0;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

endmodule
